>>> sv/ppwm_pkg.sv
// Package: shared constants, state and control types for the pacing monitor.
`default_nettype none
package ppwm_pkg;

  localparam int TimeBitsDef  = 48;
  localparam int CountBitsDef = 24;
  localparam int UnitW        = 64;
  localparam int CfgIdxW      = 8;

  localparam logic [CfgIdxW-1:0] REG_ENABLE = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_WINDOW = 8'd1;

  localparam logic [23:0] WindowReset  = 24'd1000000;
  localparam logic [29:0] RateScale    = 30'd1000000000;
  localparam logic [31:0] JitterFloor  = 32'd1000;
  localparam logic [31:0] Max32        = 32'hFFFF_FFFF;
  localparam logic [23:0] Max24        = 24'hFF_FFFF;
  localparam logic [47:0] Max48        = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [4:0] {
    S_IDLE, S_IV, S_SQ, S_ACC,
    S_MEAN_LD, S_MEAN_RUN, S_AVSQ_LD, S_AVSQ_RUN, S_MSQ,
    S_SQRT_LD, S_SQRT_RUN, S_RATE_LD, S_RATE_RUN,
    S_ENC_LD, S_ENC_RUN, S_QUAL, S_OUT
  } state_e;

  typedef enum logic [2:0] {
    Q_WARMING = 3'd0,
    Q_GOOD    = 3'd1,
    Q_OK      = 3'd2,
    Q_JITTERY = 3'd3,
    Q_BAD     = 3'd4
  } quality_e;

  typedef struct packed {
    logic start;
    logic sqrt_mode;
  } unit_ctrl_t;

  typedef struct packed {
    logic busy;
  } unit_stat_t;

endpackage
`default_nettype wire

>>> sv/ppwm_if.sv
// Interfaces: packet event, summary and configuration channels.
`default_nettype none
interface ppwm_in_if;
  logic        valid;
  logic        ready;
  logic [47:0] arrival_time_us;
  logic [23:0] packet_bytes;
  logic [47:0] frame_number;
  logic        is_keyframe;
  logic [23:0] encode_time_us;
  modport source(output valid, arrival_time_us, packet_bytes, frame_number,
                 is_keyframe, encode_time_us, input ready);
  modport sink(input valid, arrival_time_us, packet_bytes, frame_number,
               is_keyframe, encode_time_us, output ready);
endinterface

interface ppwm_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] window_packets;
  logic [47:0] window_bytes;
  logic [31:0] rate_millifps;
  logic [31:0] mean_interval_us;
  logic [31:0] min_interval_us;
  logic [31:0] max_interval_us;
  logic [31:0] jitter_us;
  logic [23:0] mean_encode_us;
  logic [23:0] peak_encode_us;
  logic [47:0] closing_frame;
  logic        closing_keyframe;
  logic [2:0]  pacing_quality;
  modport source(output valid, window_packets, window_bytes, rate_millifps,
                 mean_interval_us, min_interval_us, max_interval_us, jitter_us,
                 mean_encode_us, peak_encode_us, closing_frame, closing_keyframe,
                 pacing_quality, input ready);
  modport sink(input valid, window_packets, window_bytes, rate_millifps,
               mean_interval_us, min_interval_us, max_interval_us, jitter_us,
               mean_encode_us, peak_encode_us, closing_frame, closing_keyframe,
               pacing_quality, output ready);
endinterface

interface ppwm_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [23:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> sv/ppwm_step_unit.sv
// Shared unit: one restoring divide bit or one square-root digit per cycle.
`default_nettype none
module ppwm_step_unit (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire ppwm_pkg::unit_ctrl_t   ctrl_i,
  input  wire logic [63:0]            num_i,
  input  wire logic [63:0]            den_i,
  output ppwm_pkg::unit_stat_t        stat_o,
  output logic [63:0]                 res_o
);
  import ppwm_pkg::*;

  logic [UnitW-1:0] rem_q, d_q, v_q, q_q;
  logic [6:0]       cnt_q;
  logic             busy_q, mode_q;
  logic [UnitW:0]   r, trial, diff;
  logic             ge;

  always_comb begin
    if (mode_q) begin
      r     = {rem_q[UnitW-2:0], d_q[UnitW-1:UnitW-2]};
      trial = {q_q[UnitW-2:0], 2'b01};
    end else begin
      r     = {rem_q, d_q[UnitW-1]};
      trial = {1'b0, v_q};
    end
    ge   = (r >= trial);
    diff = r - trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (ctrl_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= ctrl_i.sqrt_mode ? 7'd32 : 7'd64;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      rem_q  <= '0;
      d_q    <= num_i;
      v_q    <= den_i;
      q_q    <= '0;
      mode_q <= ctrl_i.sqrt_mode;
    end else if (busy_q) begin
      rem_q <= ge ? diff[UnitW-1:0] : r[UnitW-1:0];
      q_q   <= {q_q[UnitW-2:0], ge};
      d_q   <= mode_q ? {d_q[UnitW-3:0], 2'b00} : {d_q[UnitW-2:0], 1'b0};
    end
  end

  assign stat_o.busy = busy_q;
  assign res_o       = q_q;
endmodule
`default_nettype wire

>>> sv/packet_pacing_window_monitor_top.sv
// Top level: packet pacing window monitor with a shared divide/sqrt sequencer.
//
//  channel  | dir | handshake       | carries
//  ---------+-----+-----------------+-----------------------------------------
//  in_if    | in  | valid/ready     | one packet event item
//  out_if   | out | valid/ready     | one window summary item
//  cfg_if   | in  | valid/ready     | register index + write data (always ready)
//
// An event that does not close a window passes through accept, interval,
// square and update. A closing event adds up to four divisions and one
// square root on the shared step unit. in_if.ready is high only in idle.
// Reset clears all accumulators and sets window_us to 1000000. A summary
// waits in the output register while the next events are taken; only a
// further close stalls on it.
`default_nettype none
module packet_pacing_window_monitor_top #(
  parameter int TIME_BITS  = ppwm_pkg::TimeBitsDef,
  parameter int COUNT_BITS = ppwm_pkg::CountBitsDef
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ppwm_in_if.sink     in_if,
  ppwm_out_if.source  out_if,
  ppwm_cfg_if.sink    cfg_if
);
  import ppwm_pkg::*;

  localparam int RateW = COUNT_BITS + 30;

  state_e state_q, state_d;

  // configuration
  logic        enable_q;
  logic [23:0] window_q;

  // window accumulators
  logic [TIME_BITS-1:0]  last_q, begin_q;
  logic [COUNT_BITS-1:0] count_q;
  logic [47:0]           bytes_q, isum_q, esum_q;
  logic [63:0]           sqsum_q;
  logic [31:0]           imin_q, imax_q;
  logic [23:0]           emax_q;

  // latched event
  logic [TIME_BITS-1:0] now_q;
  logic [23:0]          pbytes_q, enc_q;
  logic [47:0]          frame_q;
  logic                 key_q;

  // intermediate results
  logic [31:0] iv_q, mean_q, jit_q, rate_q;
  logic [63:0] ivsq_q, avsq_q, msq_q;
  logic [23:0] menc_q;
  quality_e    qual_q, qual_c;

  logic                 out_valid_q;
  logic                 in_acc, out_load;
  logic [TIME_BITS-1:0] diff_t, elapsed;
  logic [63:0]          n64, unit_res;
  unit_ctrl_t           ctrl;
  unit_stat_t           ust;
  logic [63:0]          num, den;
  logic [RateW-1:0]     rate_num;
  logic [39:0]          j20, m3, m7;

  assign in_if.ready  = (state_q == S_IDLE);
  assign cfg_if.ready = 1'b1;
  assign in_acc       = in_if.valid && in_if.ready;
  assign out_load     = (state_q == S_OUT) && (!out_valid_q || out_if.ready);

  assign diff_t   = now_q - last_q;
  assign elapsed  = now_q - begin_q;
  assign n64      = 64'(count_q) - 64'd1;
  assign rate_num = RateW'(count_q) * RateW'(RateScale);

  ppwm_step_unit u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .num_i  (num),
    .den_i  (den),
    .stat_o (ust),
    .res_o  (unit_res)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    ctrl.start     = 1'b0;
    ctrl.sqrt_mode = 1'b0;
    num            = '0;
    den            = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc && enable_q) begin
          state_d = S_IV;
        end
      end
      S_IV:  state_d = S_SQ;
      S_SQ:  state_d = S_ACC;
      S_ACC: begin
        // window closes once the elapsed time reaches window_us
        state_d = (elapsed < TIME_BITS'(window_q)) ? S_IDLE : S_MEAN_LD;
      end
      S_MEAN_LD: begin
        if (count_q <= COUNT_BITS'(1)) begin
          state_d = S_RATE_LD;
        end else begin
          ctrl.start = 1'b1;
          num        = {16'd0, isum_q};
          den        = n64;
          state_d    = S_MEAN_RUN;
        end
      end
      S_MEAN_RUN: if (!ust.busy) state_d = S_AVSQ_LD;
      S_AVSQ_LD: begin
        ctrl.start = 1'b1;
        num        = sqsum_q;
        den        = n64;
        state_d    = S_AVSQ_RUN;
      end
      S_AVSQ_RUN: if (!ust.busy) state_d = S_MSQ;
      S_MSQ:      state_d = S_SQRT_LD;
      S_SQRT_LD: begin
        if (avsq_q > msq_q) begin
          ctrl.start     = 1'b1;
          ctrl.sqrt_mode = 1'b1;
          num            = avsq_q - msq_q;
          state_d        = S_SQRT_RUN;
        end else begin
          state_d = S_RATE_LD;
        end
      end
      S_SQRT_RUN: if (!ust.busy) state_d = S_RATE_LD;
      S_RATE_LD: begin
        if (elapsed == '0) begin
          state_d = S_ENC_LD;
        end else begin
          ctrl.start = 1'b1;
          num        = 64'(rate_num);
          den        = 64'(elapsed);
          state_d    = S_RATE_RUN;
        end
      end
      S_RATE_RUN: if (!ust.busy) state_d = S_ENC_LD;
      S_ENC_LD: begin
        ctrl.start = 1'b1;
        num        = {16'd0, esum_q};
        den        = 64'(count_q);
        state_d    = S_ENC_RUN;
      end
      S_ENC_RUN: if (!ust.busy) state_d = S_QUAL;
      S_QUAL:    state_d = S_OUT;
      S_OUT:     if (out_load) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // quality class from jitter against mean
  always_comb begin
    j20 = (40'(jit_q) << 4) + (40'(jit_q) << 2);
    m3  = (40'(mean_q) << 1) + 40'(mean_q);
    m7  = (40'(mean_q) << 3) - 40'(mean_q);
    if (mean_q == '0) begin
      qual_c = Q_WARMING;
    end else if (jit_q < JitterFloor || j20 < 40'(mean_q)) begin
      qual_c = Q_GOOD;
    end else if (j20 < m3) begin
      qual_c = Q_OK;
    end else if (j20 < m7) begin
      qual_c = Q_JITTERY;
    end else begin
      qual_c = Q_BAD;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      window_q <= WindowReset;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_ENABLE: enable_q <= cfg_if.data[0];
        REG_WINDOW: window_q <= cfg_if.data;
        default: ;
      endcase
    end
  end

  // window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      begin_q <= '0;
      count_q <= '0;
      bytes_q <= '0;
      isum_q  <= '0;
      sqsum_q <= '0;
      imin_q  <= '0;
      imax_q  <= '0;
      esum_q  <= '0;
      emax_q  <= '0;
    end else if (state_q == S_ACC) begin
      logic [48:0] bsum, isum, esum;
      logic [64:0] ssum;
      bsum = {1'b0, bytes_q} + 49'(pbytes_q);
      esum = {1'b0, esum_q} + 49'(enc_q);
      isum = {1'b0, isum_q} + 49'(iv_q);
      ssum = {1'b0, sqsum_q} + {1'b0, ivsq_q};
      last_q  <= now_q;
      if (count_q != '1) count_q <= count_q + COUNT_BITS'(1);
      bytes_q <= bsum[48] ? Max48 : bsum[47:0];
      esum_q  <= esum[48] ? Max48 : esum[47:0];
      if (enc_q > emax_q) emax_q <= enc_q;
      // first packet of a window brings no interval
      if (count_q != '0) begin
        isum_q  <= isum[48] ? Max48 : isum[47:0];
        sqsum_q <= ssum[64] ? '1 : ssum[63:0];
        if (imin_q == '0 || iv_q < imin_q) imin_q <= iv_q;
        if (iv_q > imax_q) imax_q <= iv_q;
      end
    end else if (out_load) begin
      begin_q <= now_q;
      count_q <= '0;
      bytes_q <= '0;
      isum_q  <= '0;
      sqsum_q <= '0;
      imin_q  <= '0;
      imax_q  <= '0;
      esum_q  <= '0;
      emax_q  <= '0;
    end
  end

  // event latch, per-event interval arithmetic and close-time arithmetic
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      now_q    <= TIME_BITS'(in_if.arrival_time_us);
      pbytes_q <= in_if.packet_bytes;
      frame_q  <= in_if.frame_number;
      key_q    <= in_if.is_keyframe;
      enc_q    <= in_if.encode_time_us;
    end
    case (state_q)
      S_IV: iv_q <= (diff_t > TIME_BITS'(Max32)) ? Max32 : diff_t[31:0];
      S_SQ: ivsq_q <= 64'(iv_q) * 64'(iv_q);
      S_MEAN_LD: begin
        mean_q <= '0;
        jit_q  <= '0;
      end
      S_MEAN_RUN: if (!ust.busy) mean_q <= (unit_res > 64'(Max32)) ? Max32 : unit_res[31:0];
      S_AVSQ_RUN: if (!ust.busy) avsq_q <= unit_res;
      S_MSQ:      msq_q <= 64'(mean_q) * 64'(mean_q);
      S_SQRT_RUN: if (!ust.busy) jit_q <= unit_res[31:0];
      S_RATE_LD:  rate_q <= Max32;
      S_RATE_RUN: if (!ust.busy) rate_q <= (unit_res > 64'(Max32)) ? Max32 : unit_res[31:0];
      S_ENC_RUN:  if (!ust.busy) menc_q <= (unit_res > 64'(Max24)) ? Max24 : unit_res[23:0];
      S_QUAL:     qual_q <= qual_c;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_if.window_packets   <= (32'(count_q) > 32'(Max24)) ? Max24 : 24'(count_q);
      out_if.window_bytes     <= bytes_q;
      out_if.rate_millifps    <= rate_q;
      out_if.mean_interval_us <= mean_q;
      out_if.min_interval_us  <= imin_q;
      out_if.max_interval_us  <= imax_q;
      out_if.jitter_us        <= jit_q;
      out_if.mean_encode_us   <= menc_q;
      out_if.peak_encode_us   <= emax_q;
      out_if.closing_frame    <= frame_q;
      out_if.closing_keyframe <= key_q;
      out_if.pacing_quality   <= qual_q;
    end
  end

  assign out_if.valid = out_valid_q;

  // checks
  a_ready_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_if.ready && ust.busy)) else $error("input ready while step unit busy");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_if.valid) else $error("summary load did not raise valid");

  a_count_at_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ENC_LD) |-> (count_q != '0)) else $error("close with empty window");

  a_clear_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (count_q == '0)) else $error("window not cleared after close");

endmodule
`default_nettype wire
